### hdl/ccb_pkg.sv
package ccb_pkg;

  localparam int NUM_ANTENNAS = 8;
  localparam int NUM_PAIRS    = NUM_ANTENNAS * (NUM_ANTENNAS - 1) / 2;
  localparam int ANT_W        = 4;
  localparam int PAIR_W       = 5;
  localparam int FRAC_BITS    = 4;
  localparam int TREE_GROUP   = 4;
  localparam int NUM_GROUPS   = (NUM_PAIRS + TREE_GROUP - 1) / TREE_GROUP;
  localparam int DIV_STEP     = 4;

  localparam logic [ANT_W-1:0] ACTIVE_MIN   = ANT_W'(2);
  localparam logic [ANT_W-1:0] ACTIVE_RESET = ANT_W'(NUM_ANTENNAS);

  typedef struct packed {
    logic valid;
    logic neg;
  } ccb_tag_t;

  function automatic logic [ANT_W-1:0] clamp_active(input logic [ANT_W-1:0] n);
    logic [ANT_W-1:0] c;
    c = n;
    if (n < ACTIVE_MIN) c = ACTIVE_MIN;
    if (n > ACTIVE_RESET) c = ACTIVE_RESET;
    return c;
  endfunction

  // n * (n - 1) / 2 for a clamped antenna count
  function automatic logic [PAIR_W-1:0] pair_count(input logic [ANT_W-1:0] n);
    logic [PAIR_W-1:0] p;
    case (n)
      4'd2:    p = 5'd1;
      4'd3:    p = 5'd3;
      4'd4:    p = 5'd6;
      4'd5:    p = 5'd10;
      4'd6:    p = 5'd15;
      4'd7:    p = 5'd21;
      default: p = 5'd28;
    endcase
    return p;
  endfunction

endpackage

### hdl/ccb_div.sv
module ccb_div #(
  parameter int MAG_W = 27,
  parameter int DIV_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [MAG_W-1:0]  dividend,
  input  logic [DIV_W-1:0]  divisor,
  input  ccb_pkg::ccb_tag_t tag_in,
  output logic [MAG_W-1:0]  quotient,
  output ccb_pkg::ccb_tag_t tag_out
);
  import ccb_pkg::*;

  localparam int NSTG  = (MAG_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W = NSTG * DIV_STEP;

  logic [DIV_W-1:0] rem_q    [NSTG];
  logic [PAD_W-1:0] quo_q    [NSTG];
  logic [PAD_W-1:0] num_q    [NSTG-1];
  ccb_tag_t         tag_q    [NSTG];
  logic [DIV_W-1:0] rem_next [NSTG];
  logic [PAD_W-1:0] quo_next [NSTG];
  logic [PAD_W-1:0] num_next [NSTG-1];

  // Long division, DIV_STEP quotient bits per stage, MSB first
  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic [DIV_W-1:0] rem_in;
    logic [DIV_W-1:0] rem_out;
    logic [PAD_W-1:0] num_in;
    logic [PAD_W-1:0] num_out;
    logic [PAD_W-1:0] quo_in;
    logic [PAD_W-1:0] quo_out;

    if (s == 0) begin : g_head
      assign rem_in = '0;
      assign num_in = PAD_W'(dividend);
      assign quo_in = '0;
    end else begin : g_body
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic [DIV_W:0] part;
      rem_out = rem_in;
      num_out = num_in;
      quo_out = quo_in;
      for (int b = 0; b < DIV_STEP; b++) begin
        part    = {rem_out, num_out[PAD_W-1]};
        num_out = {num_out[PAD_W-2:0], 1'b0};
        if (part >= {1'b0, divisor}) begin
          part    = part - {1'b0, divisor};
          quo_out = {quo_out[PAD_W-2:0], 1'b1};
        end else begin
          quo_out = {quo_out[PAD_W-2:0], 1'b0};
        end
        rem_out = part[DIV_W-1:0];
      end
    end

    assign rem_next[s] = rem_out;
    assign quo_next[s] = quo_out;
    if (s < NSTG - 1) begin : g_pass
      assign num_next[s] = num_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NSTG; s++) tag_q[s] <= '0;
    end else if (en) begin
      tag_q[0] <= tag_in;
      for (int s = 1; s < NSTG; s++) tag_q[s] <= tag_q[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NSTG; s++) begin
        rem_q[s] <= rem_next[s];
        quo_q[s] <= quo_next[s];
      end
      for (int s = 0; s < NSTG - 1; s++) num_q[s] <= num_next[s];
    end
  end

  assign quotient = quo_q[NSTG-1][MAG_W-1:0];
  assign tag_out  = tag_q[NSTG-1];

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    tag_out.valid |-> rem_q[NSTG-1] < divisor)
    else $error("division remainder not below divisor");

endmodule

### hdl/ccb_sqrt.sv
module ccb_sqrt #(
  parameter int ROOT_W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [2*ROOT_W-1:0] radicand,
  input  ccb_pkg::ccb_tag_t   tag_in,
  output logic [ROOT_W-1:0]   root,
  output ccb_pkg::ccb_tag_t   tag_out
);
  import ccb_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int T_W   = REM_W + 2;

  logic [REM_W-1:0]  rem_q     [ROOT_W];
  logic [ROOT_W-1:0] root_q    [ROOT_W];
  logic [RAD_W-1:0]  rad_q     [ROOT_W-1];
  ccb_tag_t          tag_q     [ROOT_W];
  logic [REM_W-1:0]  rem_next  [ROOT_W];
  logic [ROOT_W-1:0] root_next [ROOT_W];
  logic [RAD_W-1:0]  rad_next  [ROOT_W-1];

  // Restoring square root, one root bit per stage
  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [T_W-1:0]    work;
    logic [T_W-1:0]    trial;

    if (s == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
    end else begin : g_body
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    assign trial = T_W'({root_in, 2'b01});

    always_comb begin
      work = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
      if (work >= trial) begin
        work         = work - trial;
        root_next[s] = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        root_next[s] = {root_in[ROOT_W-2:0], 1'b0};
      end
      rem_next[s] = work[REM_W-1:0];
    end

    if (s < ROOT_W - 1) begin : g_pass
      assign rad_next[s] = {rad_in[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < ROOT_W; s++) tag_q[s] <= '0;
    end else if (en) begin
      tag_q[0] <= tag_in;
      for (int s = 1; s < ROOT_W; s++) tag_q[s] <= tag_q[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < ROOT_W; s++) begin
        rem_q[s]  <= rem_next[s];
        root_q[s] <= root_next[s];
      end
      for (int s = 0; s < ROOT_W - 1; s++) rad_q[s] <= rad_next[s];
    end
  end

  assign root    = root_q[ROOT_W-1];
  assign tag_out = tag_q[ROOT_W-1];

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    tag_out.valid |-> rem_q[ROOT_W-1] <= REM_W'({root, 1'b0}))
    else $error("square root remainder exceeds twice the root");

endmodule

### hdl/cross_correlation_beam.sv
// Cross-correlation beam of an antenna array.
// Each input transaction carries one delay-aligned sample per antenna on
// ant0_sample .. ant7_sample. The block sums the products of all distinct
// pairs among the first active antennas, divides by the pair count
// (truncating toward zero) and returns sign(mean) * floor(sqrt(|mean|) * 16)
// on beam_value, one result transaction per input transaction, in order.
// The active antenna count is written on the cfg channel (clamped to 2..8);
// cfg_ready is always high. The user must write it only while the pipeline
// is empty; the block leaves this unchecked. Throughput: one transaction per
// cycle while out_ready stays high. From acceptance to the result register
// the stages are: product, two adder-tree stages, magnitude,
// long-division stages at four quotient bits each, then one
// square-root stage per root bit.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and sets the active antenna count to 8.
module cross_correlation_beam #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [ccb_pkg::ANT_W-1:0]                   cfg_data,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [SAMPLE_BITS-1:0]               ant0_sample,
  input  logic signed [SAMPLE_BITS-1:0]               ant1_sample,
  input  logic signed [SAMPLE_BITS-1:0]               ant2_sample,
  input  logic signed [SAMPLE_BITS-1:0]               ant3_sample,
  input  logic signed [SAMPLE_BITS-1:0]               ant4_sample,
  input  logic signed [SAMPLE_BITS-1:0]               ant5_sample,
  input  logic signed [SAMPLE_BITS-1:0]               ant6_sample,
  input  logic signed [SAMPLE_BITS-1:0]               ant7_sample,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic signed [SAMPLE_BITS+ccb_pkg::FRAC_BITS:0] beam_value
);
  import ccb_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int SUM_W  = PROD_W + $clog2(NUM_PAIRS);
  localparam int MAG_W  = SUM_W - 1;
  localparam int MEAN_W = PROD_W - 1;
  localparam int ROOT_W = SAMPLE_BITS + FRAC_BITS;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int OUT_W  = ROOT_W + 1;

  localparam logic signed [OUT_W-1:0] BEAM_MAX = OUT_W'(1) << (ROOT_W - 1);
  localparam logic signed [OUT_W-1:0] BEAM_MIN = -BEAM_MAX;

  logic [ANT_W-1:0]  n_act;
  logic [PAIR_W-1:0] pairs;
  logic              en;

  logic signed [SAMPLE_BITS-1:0] samp [NUM_ANTENNAS];

  logic signed [PROD_W-1:0] prod_next [NUM_PAIRS];
  logic signed [PROD_W-1:0] prod_q    [NUM_PAIRS];
  logic signed [SUM_W-1:0]  part_next [NUM_GROUPS];
  logic signed [SUM_W-1:0]  part_q    [NUM_GROUPS];
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [SUM_W-1:0]  sum_q;
  logic [MAG_W-1:0]         mag_q;
  logic                     neg_q;
  logic                     s1_valid;
  logic                     s2_valid;
  logic                     s3_valid;
  logic                     s4_valid;

  ccb_tag_t          div_tag_in;
  ccb_tag_t          div_tag;
  ccb_tag_t          sqrt_tag;
  logic [MAG_W-1:0]  mean_mag;
  logic [RAD_W-1:0]  radicand;
  logic [ROOT_W-1:0] root;

  // Configuration: stored already clamped, with its pair count
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_act <= ACTIVE_RESET;
      pairs <= pair_count(ACTIVE_RESET);
    end else if (cfg_valid) begin
      n_act <= clamp_active(cfg_data);
      pairs <= pair_count(clamp_active(cfg_data));
    end
  end

  // Advance the pipeline unless a result waits at a stalled receiver
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign samp[0] = ant0_sample;
  assign samp[1] = ant1_sample;
  assign samp[2] = ant2_sample;
  assign samp[3] = ant3_sample;
  assign samp[4] = ant4_sample;
  assign samp[5] = ant5_sample;
  assign samp[6] = ant6_sample;
  assign samp[7] = ant7_sample;

  // Stage 1: pair products, zero where the upper lane is not active
  for (genvar i = 0; i < NUM_ANTENNAS; i++) begin : g_row
    for (genvar j = i + 1; j < NUM_ANTENNAS; j++) begin : g_col
      localparam int K = i * (2 * NUM_ANTENNAS - i - 1) / 2 + j - i - 1;
      assign prod_next[K] = (ANT_W'(j) < n_act) ?
                            PROD_W'(samp[i]) * PROD_W'(samp[j]) : '0;
    end
  end

  // Stage 2: group sums
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      part_next[g] = '0;
      for (int t = 0; t < TREE_GROUP; t++) begin
        if (g * TREE_GROUP + t < NUM_PAIRS) begin
          part_next[g] = part_next[g] + SUM_W'(prod_q[g * TREE_GROUP + t]);
        end
      end
    end
  end

  // Stage 3: total
  always_comb begin
    sum_next = '0;
    for (int g = 0; g < NUM_GROUPS; g++) sum_next = sum_next + part_q[g];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q <= prod_next;
      part_q <= part_next;
      sum_q  <= sum_next;
      // Stage 4: sign and magnitude for the divider
      neg_q  <= sum_q[SUM_W-1];
      mag_q  <= sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
    end
  end

  assign div_tag_in.valid = s4_valid;
  assign div_tag_in.neg   = neg_q;

  ccb_div #(
    .MAG_W (MAG_W),
    .DIV_W (PAIR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .dividend (mag_q),
    .divisor  (pairs),
    .tag_in   (div_tag_in),
    .quotient (mean_mag),
    .tag_out  (div_tag)
  );

  // Scale by 256 so the root carries four fraction bits
  assign radicand = RAD_W'({mean_mag[MEAN_W-1:0], {(2 * FRAC_BITS){1'b0}}});

  ccb_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .radicand (radicand),
    .tag_in   (div_tag),
    .root     (root),
    .tag_out  (sqrt_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sqrt_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beam_value <= sqrt_tag.neg ? -OUT_W'(root) : OUT_W'(root);
    end
  end

  a_pairs_match: assert property (@(posedge clk) disable iff (rst)
    pairs == pair_count(n_act))
    else $error("pair count out of step with active antenna count");

  a_active_range: assert property (@(posedge clk) disable iff (rst)
    n_act >= ACTIVE_MIN && n_act <= ACTIVE_RESET)
    else $error("active antenna count outside clamp range");

  a_beam_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> beam_value <= BEAM_MAX && beam_value >= BEAM_MIN)
    else $error("beam value beyond largest possible root");

endmodule

### tb/cross_correlation_beam_checker.sv
module cross_correlation_beam_checker #(
  parameter int SAMPLE_W = 12
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 cfg_valid,
  input  logic                                                 cfg_ready,
  input  logic [ccb_pkg::ANT_W-1:0]                            cfg_data,
  input  logic                                                 in_valid,
  input  logic                                                 in_ready,
  input  logic [ccb_pkg::NUM_ANTENNAS-1:0][SAMPLE_W-1:0]       lanes,
  input  logic                                                 out_valid,
  input  logic                                                 out_ready,
  input  logic signed [SAMPLE_W+ccb_pkg::FRAC_BITS:0]          beam_value,
  output int                                                   mismatches,
  output int                                                   outstanding,
  output int                                                   beams_checked
);

  localparam int OUT_W = SAMPLE_W + ccb_pkg::FRAC_BITS + 1;
  localparam int ROOT_BITS = SAMPLE_W + ccb_pkg::FRAC_BITS + 1;

  logic [ccb_pkg::ANT_W-1:0] active_count;
  logic signed [OUT_W-1:0]   expected_beams[$];

  // Signed square root of the truncated mean over all pairs among the first count lanes, 4 fraction bits.
  function automatic logic signed [OUT_W-1:0] mean_pair_root(
    input logic [ccb_pkg::NUM_ANTENNAS-1:0][SAMPLE_W-1:0] samples,
    input logic [ccb_pkg::ANT_W-1:0]                      count
  );
    int     n;
    longint pair_sum;
    longint pair_n;
    longint avg;
    longint scaled;
    longint root;
    longint cand;
    n = int'(count);
    if (n < int'(ccb_pkg::ACTIVE_MIN)) n = int'(ccb_pkg::ACTIVE_MIN);
    if (n > ccb_pkg::NUM_ANTENNAS) n = ccb_pkg::NUM_ANTENNAS;
    pair_sum = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        pair_sum += longint'($signed(samples[i])) * longint'($signed(samples[j]));
      end
    end
    pair_n = longint'(n * (n - 1) / 2);
    // integer division truncates toward zero
    avg = pair_sum / pair_n;
    scaled = (avg < 0 ? -avg : avg) << (2 * ccb_pkg::FRAC_BITS);
    root = 0;
    for (int b = ROOT_BITS; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand <= scaled) root = cand;
    end
    return OUT_W'(avg < 0 ? -root : root);
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
    beams_checked = 0;
    active_count = ccb_pkg::ACTIVE_RESET;
  end

  always @(posedge clk) begin : watch
    logic signed [OUT_W-1:0] want;
    if (rst) begin
      active_count = ccb_pkg::ACTIVE_RESET;
      expected_beams.delete();
    end else begin
      // compare before pushing: a result can never belong to this edge's input
      if (out_valid && out_ready) begin
        if (expected_beams.size() == 0) begin
          $error("beam_value transaction with nothing expected: got %0d", beam_value);
          mismatches++;
        end else begin
          want = expected_beams.pop_front();
          beams_checked++;
          if (beam_value !== want) begin
            $error("beam_value mismatch: expected %0d, got %0d", want, beam_value);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) expected_beams.push_back(mean_pair_root(lanes, active_count));
      if (cfg_valid && cfg_ready) active_count = cfg_data;
    end
    outstanding = expected_beams.size();
  end

endmodule

### tb/cross_correlation_beam_test.sv
module cross_correlation_beam_test;

  import ccb_pkg::*;

  localparam int SAMPLE_W     = 12;
  localparam int OUT_W        = SAMPLE_W + FRAC_BITS + 1;
  localparam int NUM_DIRECTED = 16;
  localparam int NUM_PHASES   = 16;
  localparam int PHASE_ITEMS  = 96;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 250000;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef logic [NUM_ANTENNAS-1:0][SAMPLE_W-1:0] lane_set_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [ANT_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  lane_set_t                lanes;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [OUT_W-1:0]  beam_value;

  int  mismatches;
  int  outstanding;
  int  beams_checked;
  int  cycles;
  int  items_sent;
  bit  steady;

  cross_correlation_beam #(
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ant0_sample(lanes[0]),
    .ant1_sample(lanes[1]),
    .ant2_sample(lanes[2]),
    .ant3_sample(lanes[3]),
    .ant4_sample(lanes[4]),
    .ant5_sample(lanes[5]),
    .ant6_sample(lanes[6]),
    .ant7_sample(lanes[7]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .beam_value (beam_value)
  );

  cross_correlation_beam_checker #(
    .SAMPLE_W(SAMPLE_W)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .lanes        (lanes),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .beam_value   (beam_value),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .beams_checked(beams_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $error("run stopped at the cycle limit with %0d results outstanding", outstanding);
      $display("cross_correlation_beam test failed");
      $finish;
    end
  end

  // Receiver: unless steady, stall a random number of cycles ahead of each result.
  initial begin : result_drain
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_extreme();
    case ($urandom_range(0, 6))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MIN + 1'b1;
      2:       return '1;
      3:       return '0;
      4:       return SAMPLE_W'(1);
      5:       return SAMPLE_MAX - 1'b1;
      default: return SAMPLE_MAX;
    endcase
  endfunction

  function automatic lane_set_t random_lanes();
    lane_set_t             v;
    int                    kind;
    bit                    flip;
    logic [SAMPLE_W-1:0]   common;
    kind = $urandom_range(0, 4);
    flip = $urandom_range(0, 1);
    common = pick_extreme();
    for (int i = 0; i < NUM_ANTENNAS; i++) begin
      case (kind)
        0: v[i] = SAMPLE_W'($urandom);
        1: v[i] = flip ? common : pick_extreme();
        // one sign across all lanes: large positive means
        2: v[i] = flip ? SAMPLE_W'(-$urandom_range(1, 2048)) : SAMPLE_W'($urandom_range(0, 2047));
        // alternating signs: mostly negative means
        3: v[i] = (((i % 2) == 1) != flip) ? SAMPLE_W'(-$urandom_range(1, 2048))
                                           : SAMPLE_W'($urandom_range(0, 2047));
        // tiny values: truncation of small sums toward zero
        default: v[i] = SAMPLE_W'($urandom_range(0, 8) - 4);
      endcase
    end
    return v;
  endfunction

  function automatic lane_set_t directed_lanes(input int k);
    lane_set_t v;
    v = '0;
    case (k)
      0: v = '0;
      1: v = {NUM_ANTENNAS{SAMPLE_MIN}};
      2: v = {NUM_ANTENNAS{SAMPLE_MAX}};
      3: for (int i = 0; i < NUM_ANTENNAS; i++) v[i] = (i % 2 == 1) ? SAMPLE_MIN : SAMPLE_MAX;
      4: begin
        v[0] = SAMPLE_MIN;
        v[1] = SAMPLE_MAX;
      end
      5: begin
        v[0] = SAMPLE_W'(1);
        v[1] = '1;
      end
      6: for (int i = 0; i < NUM_ANTENNAS; i++) v[i] = SAMPLE_W'(1);
      7: v = '1;
      8: v[0] = SAMPLE_MAX;
      9: begin
        v[6] = SAMPLE_MIN;
        v[7] = SAMPLE_MIN;
      end
      10: v = {NUM_ANTENNAS{SAMPLE_W'('h555)}};
      11: v = {NUM_ANTENNAS{SAMPLE_W'('hAAA)}};
      12: for (int i = 0; i < NUM_ANTENNAS; i++) v[i] = SAMPLE_W'(i * 300 - 1000);
      13: begin
        v = {NUM_ANTENNAS{SAMPLE_MAX}};
        v[0] = SAMPLE_MIN;
        v[1] = SAMPLE_MIN;
      end
      14: begin
        v[0] = SAMPLE_W'(2);
        v[1] = SAMPLE_W'(3);
      end
      default: begin
        v = {NUM_ANTENNAS{SAMPLE_MIN}};
        v[NUM_ANTENNAS-1] = SAMPLE_MAX;
      end
    endcase
    return v;
  endfunction

  // Fixed sweep first: at, below and above the legal range and each count from 3 to 8, then random counts.
  function automatic logic [ANT_W-1:0] phase_setting(input int ph);
    case (ph)
      0:       return ANT_W'(2);
      1:       return ANT_W'(0);
      2:       return ANT_W'(1);
      3:       return ANT_W'(15);
      4:       return ANT_W'(9);
      5:       return ANT_W'(3);
      6:       return ANT_W'(4);
      7:       return ANT_W'(5);
      8:       return ANT_W'(6);
      9:       return ANT_W'(7);
      10:      return ANT_W'(8);
      default: return ANT_W'($urandom_range(0, 15));
    endcase
  endfunction

  // Called at a falling edge; hold valid high across back-to-back transactions.
  task automatic send_lanes(input lane_set_t v);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    lanes <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_antenna_count(input logic [ANT_W-1:0] count);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    lanes = '0;
    steady = 1'b0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset value of the antenna count covers all eight lanes
    for (int k = 0; k < NUM_DIRECTED; k++) send_lanes(directed_lanes(k));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_antenna_count(phase_setting(ph));
      steady = (ph % 4 == 1) || ($urandom_range(0, 5) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) send_lanes(random_lanes());
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d sample transactions (%0d directed) under %0d antenna count settings,",
             items_sent, NUM_DIRECTED, NUM_PHASES + 1);
    $display("with random gaps and stalls on both sides; %0d beam results compared.",
             beams_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("cross_correlation_beam test passed");
    end else begin
      $display("cross_correlation_beam test failed");
    end
    $finish;
  end

endmodule
